// File: design/fppc_pkg.sv
// Shared types, key codes and segment patterns of the frequency preset panel controller.
package fppc_pkg;

  // Decoded key codes.
  localparam logic [4:0] KEY_DIGIT0  = 5'd0;
  localparam logic [4:0] KEY_DIGIT9  = 5'd9;
  localparam logic [4:0] KEY_ENTER   = 5'd10;
  localparam logic [4:0] KEY_PRESET  = 5'd11;
  localparam logic [4:0] KEY_BANK_DN = 5'd12;
  localparam logic [4:0] KEY_SLOT_DN = 5'd13;
  localparam logic [4:0] KEY_BANK_UP = 5'd14;
  localparam logic [4:0] KEY_SLOT_UP = 5'd15;
  localparam logic [4:0] KEY_STORE   = 5'd16;
  localparam logic [4:0] KEY_NONE    = 5'd17;

  // Digit entry modes.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_LOW  = 2'd2;

  // Slot address width in bits in the store address layout (16 slots per bank).
  localparam int SLOT_W = 4;

  // Flash length and intensity levels.
  localparam logic [3:0] FLASH_LEN  = 4'd8;
  localparam logic [3:0] LEVEL_ON   = 4'h8;
  localparam logic [3:0] LEVEL_OFF  = 4'h0;
  localparam logic [7:0] SEG_DP     = 8'h80;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } status_t;

  // Seven-segment pattern of a hexadecimal nibble.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h7E;
      4'h1: s = 8'h30;
      4'h2: s = 8'h6D;
      4'h3: s = 8'h79;
      4'h4: s = 8'h33;
      4'h5: s = 8'h5B;
      4'h6: s = 8'h5F;
      4'h7: s = 8'h70;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h7B;
      4'hA: s = 8'h77;
      4'hB: s = 8'h1F;
      4'hC: s = 8'h4E;
      4'hD: s = 8'h3D;
      4'hE: s = 8'h4F;
      default: s = 8'h47;
    endcase
    return s;
  endfunction

endpackage

// File: design/fppc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fppc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 96,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fppc_ctrl.sv
// Controller state machine: accept an item, read the stores, then commit the item.
module fppc_ctrl import fppc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: if (!status.out_full || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: the item commits once the output register can take its result.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_READ: ;
      ST_EXEC: cmd.commit = !status.out_full || out_ready;
      default: ;
    endcase
  end

endmodule

// File: design/fppc_dp.sv
// Datapath: panel state, working and saved stores, key handling, display and output register.
module fppc_dp import fppc_pkg::*; #(
  parameter int NUM_BANKS      = 6,
  parameter int SLOTS_PER_BANK = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [4:0]  in_key,
  input  logic [21:0] in_dial_freq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_display_segments,
  output logic        out_intensity_write,
  output logic [3:0]  out_intensity_level,
  output logic        out_preset_active,
  output logic [23:0] out_drive_freq,
  output logic        out_save_valid,
  output logic [6:0]  out_save_slot,
  output logic [23:0] out_save_data
);

  localparam int DEPTH = NUM_BANKS * (2 ** SLOT_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  // Panel state.
  logic [BW-1:0]     bank_r, bank_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              preset_r, preset_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [23:0]       entry_r, entry_nxt;
  logic [7:0]        blink_r;
  logic [3:0]        flash_r, flash_nxt;
  logic [4:0]        last_key_r;
  logic [23:0]       drive_r, drive_nxt;
  logic [DEPTH-1:0]  wk_vld_r, sv_vld_r;

  // Captured item.
  logic [4:0]  key_r;
  logic [21:0] dial_r;

  // Output register.
  logic        out_valid_r;
  logic [63:0] seg_r, seg_nxt;
  logic        iw_r, iw_nxt;
  logic [3:0]  il_r, il_nxt;
  logic        sav_r, sav_nxt;
  logic [6:0]  ss_r;
  logic [23:0] sd_r, sd_nxt;

  // Store ports.
  logic [AW-1:0] addr;
  logic [23:0]   wk_rdata, sv_rdata, wk_val, sv_val;
  logic          wk_we, sv_we;
  logic [23:0]   wk_wdata;

  // Per-item working values.
  logic [4:0]  key_eff;
  logic        act, shown, lead;
  logic [1:0]  mode0;
  logic [23:0] freq;
  logic [3:0]  nib;

  assign addr = AW'({bank_r, slot_r});

  fppc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_working (
    .clk(clk), .we(wk_we), .waddr(addr), .wdata(wk_wdata), .raddr(addr), .rdata(wk_rdata)
  );

  fppc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_saved (
    .clk(clk), .we(sv_we), .waddr(addr), .wdata(sd_nxt), .raddr(addr), .rdata(sv_rdata)
  );

  // Entries never written read as zero.
  assign wk_val = wk_vld_r[addr] ? wk_rdata : 24'h0;
  assign sv_val = sv_vld_r[addr] ? sv_rdata : 24'h0;

  // Shown frequency, display and key handling for one item.
  always_comb begin
    key_eff    = (key_r > KEY_NONE) ? KEY_NONE : key_r;
    act        = (last_key_r == KEY_NONE);
    mode0      = preset_r ? mode_r : MODE_OFF;
    drive_nxt  = drive_r;
    if (preset_r) begin
      if (mode_r != MODE_OFF) begin
        freq = entry_r;
      end else begin
        freq      = wk_val;
        drive_nxt = wk_val;
      end
    end else begin
      freq = {2'b00, dial_r};
    end

    // Frequency digits with leading-zero blanking and blink.
    shown   = (mode0 != MODE_OFF) ? blink_r[5] : 1'b1;
    lead    = 1'b0;
    seg_nxt = 64'h0;
    for (int i = 0; i < 6; i++) begin
      nib = freq[23-4*i -: 4];
      if (nib != 4'h0 || i == 2) lead = 1'b1;
      if (lead && shown) begin
        seg_nxt[63-8*i -: 8] = seg_of(nib) | (((i == 1) || (i == 4)) ? SEG_DP : 8'h00);
      end
    end
    seg_nxt[15:8] = seg_of(4'(bank_r) + 4'd10);
    seg_nxt[7:0]  = seg_of(4'(slot_r));

    // Intensity flash.
    iw_nxt    = (flash_r != 4'd0);
    il_nxt    = (flash_r == 4'd0 || flash_r == 4'd1) ? LEVEL_OFF : LEVEL_ON;
    flash_nxt = (flash_r != 4'd0) ? flash_r - 4'd1 : 4'd0;

    // Key actions.
    bank_nxt   = bank_r;
    slot_nxt   = slot_r;
    preset_nxt = preset_r;
    mode_nxt   = mode0;
    entry_nxt  = entry_r;
    wk_we      = 1'b0;
    wk_wdata   = entry_r;
    sv_we      = 1'b0;
    sav_nxt    = 1'b0;
    sd_nxt     = 24'h0;
    if (act) begin
      case (key_eff) inside
        [KEY_DIGIT0:KEY_DIGIT9]: begin
          if (mode0 == MODE_HIGH) begin
            entry_nxt = {entry_r[19:4], key_eff[3:0], 4'h0};
          end else if (mode0 == MODE_LOW) begin
            entry_nxt = {entry_r[23:4], key_eff[3:0]};
          end else begin
            entry_nxt = {16'h0, key_eff[3:0], 4'h0};
            mode_nxt  = MODE_HIGH;
          end
        end
        KEY_ENTER: begin
          if (preset_r) begin
            wk_we = 1'b1;
            if (mode0 != MODE_OFF) begin
              wk_wdata = entry_r;
              mode_nxt = MODE_OFF;
            end else begin
              wk_wdata = sv_val;
            end
          end
        end
        KEY_PRESET: begin
          preset_nxt = !preset_r;
          if (preset_r) drive_nxt = 24'hFFFFFF;
        end
        KEY_BANK_DN: begin
          if (mode0 == MODE_HIGH) begin
            mode_nxt = MODE_LOW;
          end else begin
            bank_nxt = (bank_r == '0) ? BW'(NUM_BANKS - 1) : bank_r - 1'b1;
          end
        end
        KEY_SLOT_DN: begin
          slot_nxt = (slot_r == '0) ? SLOT_W'(SLOTS_PER_BANK - 1) : slot_r - 1'b1;
        end
        KEY_BANK_UP: begin
          if (mode0 != MODE_OFF) begin
            mode_nxt = MODE_OFF;
          end else begin
            bank_nxt = (bank_r >= BW'(NUM_BANKS - 1)) ? '0 : bank_r + 1'b1;
          end
        end
        KEY_SLOT_UP: begin
          slot_nxt = (slot_r >= SLOT_W'(SLOTS_PER_BANK - 1)) ? '0 : slot_r + 1'b1;
        end
        KEY_STORE: begin
          if (!preset_r) begin
            wk_we    = 1'b1;
            wk_wdata = freq;
            sav_nxt  = 1'b1;
            sd_nxt   = freq;
          end else if (mode0 == MODE_OFF) begin
            sav_nxt = 1'b1;
            sd_nxt  = wk_val;
          end
          if (sav_nxt) begin
            sv_we     = 1'b1;
            flash_nxt = FLASH_LEN;
          end
        end
        default: ;
      endcase
    end
    wk_we = wk_we && cmd.commit;
    sv_we = sv_we && cmd.commit;
  end

  // Panel state and store valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= '0;
      slot_r     <= '0;
      preset_r   <= 1'b0;
      mode_r     <= MODE_OFF;
      entry_r    <= 24'h0;
      blink_r    <= 8'h0;
      flash_r    <= 4'h0;
      last_key_r <= KEY_DIGIT0;
      drive_r    <= 24'hFFFFFF;
      wk_vld_r   <= '0;
      sv_vld_r   <= '0;
    end else if (cmd.commit) begin
      bank_r     <= bank_nxt;
      slot_r     <= slot_nxt;
      preset_r   <= preset_nxt;
      mode_r     <= mode_nxt;
      entry_r    <= entry_nxt;
      blink_r    <= blink_r + 8'd1;
      flash_r    <= flash_nxt;
      last_key_r <= key_eff;
      drive_r    <= drive_nxt;
      if (wk_we) wk_vld_r[addr] <= 1'b1;
      if (sv_we) sv_vld_r[addr] <= 1'b1;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= in_key;
      dial_r <= in_dial_freq;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      seg_r <= seg_nxt;
      iw_r  <= iw_nxt;
      il_r  <= il_nxt;
      sav_r <= sav_nxt;
      ss_r  <= sav_nxt ? 7'(addr) : 7'd0;
      sd_r  <= sd_nxt;
    end
  end

  assign status.out_full      = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_display_segments = seg_r;
  assign out_intensity_write  = iw_r;
  assign out_intensity_level  = il_r;
  assign out_preset_active    = preset_r;
  assign out_drive_freq       = drive_r;
  assign out_save_valid       = sav_r;
  assign out_save_slot        = ss_r;
  assign out_save_data        = sd_r;

endmodule

// File: design/frequency_preset_panel_controller.sv
// Top level of the frequency preset panel controller.
//
// One input item per scan tick: a decoded key (in_key) and the BCD dial
// frequency (in_dial_freq), on a valid/ready channel. Each item yields
// exactly one result item on the out_ channel: eight 7-segment bytes, an
// intensity write, the preset drive state and value, and a save request.
// An item passes the accept state, a read state for the registered
// read of the working and saved stores at the selected bank and slot, and
// the commit state that updates state, writes the stores and loads the
// output register. One item is in work at a time, so a new item is taken
// only after the last one commits. in_ready is high while no item
// is in work; a result waiting in the output register does not block the
// next item until that item reaches its commit cycle, where it holds until
// the receiver takes the previous result.
// Reset clears the panel state, releases the drive lines (all ones) and
// marks every store entry as zero through per-entry valid bits, so no
// clearing pass is needed.
module frequency_preset_panel_controller import fppc_pkg::*; #(
  parameter int NUM_BANKS      = 6,
  parameter int SLOTS_PER_BANK = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_key,
  input  logic [21:0] in_dial_freq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_display_segments,
  output logic        out_intensity_write,
  output logic [3:0]  out_intensity_level,
  output logic        out_preset_active,
  output logic [23:0] out_drive_freq,
  output logic        out_save_valid,
  output logic [6:0]  out_save_slot,
  output logic [23:0] out_save_data
);

  cmd_t    cmd;
  status_t status;

  fppc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  fppc_dp #(.NUM_BANKS(NUM_BANKS), .SLOTS_PER_BANK(SLOTS_PER_BANK)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_key(in_key), .in_dial_freq(in_dial_freq),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_display_segments(out_display_segments),
    .out_intensity_write(out_intensity_write),
    .out_intensity_level(out_intensity_level),
    .out_preset_active(out_preset_active),
    .out_drive_freq(out_drive_freq),
    .out_save_valid(out_save_valid),
    .out_save_slot(out_save_slot),
    .out_save_data(out_save_data)
  );

endmodule

// File: design/fppc_checker.sv
// Port-level checks of the frequency preset panel controller and their binding.
module fppc_checker import fppc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_display_segments,
  input logic        out_intensity_write,
  input logic [3:0]  out_intensity_level,
  input logic        out_save_valid,
  input logic [6:0]  out_save_slot,
  input logic [23:0] out_save_data
);

  // A stalled result item stays valid and its display segments hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_display_segments))
    else $error("result item changed while stalled");

  // No save request means zero slot and data.
  a_save_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_save_valid |-> out_save_slot == 7'd0 && out_save_data == 24'h0)
    else $error("save fields nonzero without save request");

  // Intensity level is zero without a write, else off or on.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_intensity_write && out_intensity_level == LEVEL_OFF) ||
                  (out_intensity_write &&
                   (out_intensity_level == LEVEL_OFF || out_intensity_level == LEVEL_ON)))
    else $error("bad intensity level");

  // No result item right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind frequency_preset_panel_controller fppc_checker u_fppc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_display_segments(out_display_segments),
  .out_intensity_write(out_intensity_write),
  .out_intensity_level(out_intensity_level),
  .out_save_valid(out_save_valid), .out_save_slot(out_save_slot),
  .out_save_data(out_save_data)
);

// File: sim/tb_top.sv
// Self-checking testbench for the frequency preset panel controller.
`timescale 1ns / 100ps

module tb_top;
  import fppc_pkg::*;

  localparam int BANKS = 6;
  localparam int SLOTS = 16;
  localparam int DEPTH = BANKS * 16;
  localparam int RAND_ITEMS = 1400;

  // One result item of the panel.
  typedef struct packed {
    logic [63:0] segs;
    logic        iw;
    logic [3:0]  il;
    logic        pa;
    logic [23:0] drv;
    logic        sv;
    logic [6:0]  ss;
    logic [23:0] sd;
  } panel_out_t;

  // One row of the directed table; has_exp marks a typed-in expectation.
  typedef struct {
    logic [4:0]  key;
    logic [21:0] dial;
    bit          has_exp;
    panel_out_t  exp;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [4:0] in_key = KEY_NONE;
  logic [21:0] in_dial_freq = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_display_segments;
  logic out_intensity_write;
  logic [3:0] out_intensity_level;
  logic out_preset_active;
  logic [23:0] out_drive_freq;
  logic out_save_valid;
  logic [6:0] out_save_slot;
  logic [23:0] out_save_data;

  always #10 clk = ~clk;

  frequency_preset_panel_controller dut (.*);

  // Predicted panel state.
  logic [2:0]  p_bank;
  logic [3:0]  p_slot;
  logic        p_preset;
  logic [1:0]  p_mode;
  logic [23:0] p_entry;
  logic [7:0]  p_blink;
  logic [3:0]  p_flash;
  logic [4:0]  p_last;
  logic [23:0] p_drive;
  logic [23:0] p_work [DEPTH];
  logic [23:0] p_saved [DEPTH];

  panel_out_t pending_panels[$];
  panel_out_t typed_panels[$];
  bit         typed_flags[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit sender_done = 1'b0;

  function automatic logic [7:0] seg_pat(input logic [3:0] d);
    logic [7:0] t [16];
    t = '{8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
          8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47};
    return t[d];
  endfunction

  task automatic reset_panel();
    p_bank = '0; p_slot = '0; p_preset = 1'b0; p_mode = MODE_OFF;
    p_entry = '0; p_blink = '0; p_flash = '0; p_last = KEY_DIGIT0;
    p_drive = '1;
    for (int i = 0; i < DEPTH; i++) begin
      p_work[i] = '0;
      p_saved[i] = '0;
    end
  endtask

  // Advance the panel by one scan tick and return its outputs.
  task automatic step_panel(input logic [4:0] key_in, input logic [21:0] dial,
                            output panel_out_t r);
    logic [4:0] k;
    int addr;
    logic [23:0] fq;
    bit shown, lead;
    logic [3:0] d;
    logic [7:0] b;
    k = (key_in > KEY_NONE) ? KEY_NONE : key_in;
    addr = (p_bank * 16 + p_slot) % DEPTH;
    r = '0;
    if (p_preset) begin
      if (p_mode != MODE_OFF) fq = p_entry;
      else begin
        fq = p_work[addr];
        p_drive = fq;
      end
    end else begin
      fq = {2'b00, dial};
      p_mode = MODE_OFF;
    end
    // Render the display with blanking and blink.
    shown = (p_mode != MODE_OFF) ? p_blink[5] : 1'b1;
    lead = 1'b0;
    p_blink = p_blink + 8'd1;
    if (p_flash != 0) begin
      r.iw = 1'b1;
      r.il = (p_flash == 4'd1) ? LEVEL_OFF : LEVEL_ON;
      p_flash = p_flash - 4'd1;
    end
    for (int i = 0; i < 6; i++) begin
      d = fq[20 - 4 * i +: 4];
      b = '0;
      if (d != 0 || i == 2) lead = 1'b1;
      if (lead && shown) b = seg_pat(d) | ((i == 1 || i == 4) ? SEG_DP : 8'h00);
      r.segs[8 * (7 - i) +: 8] = b;
    end
    r.segs[15:8] = seg_pat(4'(p_bank + 4'd10));
    r.segs[7:0] = seg_pat(p_slot);
    // Act on a fresh key press only.
    if (p_last == KEY_NONE) begin
      if (k <= KEY_DIGIT9) begin
        if (p_mode == MODE_HIGH) p_entry = {p_entry[19:4], k[3:0], 4'h0};
        else if (p_mode == MODE_LOW) p_entry = {p_entry[23:4], k[3:0]};
        else begin
          p_entry = {16'h0, k[3:0], 4'h0};
          p_mode = MODE_HIGH;
        end
      end else if (k == KEY_ENTER) begin
        if (p_preset) begin
          if (p_mode != MODE_OFF) begin
            p_work[addr] = p_entry;
            p_mode = MODE_OFF;
          end else p_work[addr] = p_saved[addr];
        end
      end else if (k == KEY_PRESET) begin
        if (p_preset) begin
          p_preset = 1'b0;
          p_drive = '1;
        end else p_preset = 1'b1;
      end else if (k == KEY_BANK_DN) begin
        if (p_mode == MODE_HIGH) p_mode = MODE_LOW;
        else p_bank = (p_bank == 0 || p_bank >= BANKS) ? 3'(BANKS - 1) : p_bank - 3'd1;
      end else if (k == KEY_SLOT_DN) begin
        p_slot = (p_slot == 0) ? 4'(SLOTS - 1) : p_slot - 4'd1;
      end else if (k == KEY_BANK_UP) begin
        if (p_mode != MODE_OFF) p_mode = MODE_OFF;
        else p_bank = (p_bank >= BANKS - 1) ? 3'd0 : p_bank + 3'd1;
      end else if (k == KEY_SLOT_UP) begin
        p_slot = (p_slot >= SLOTS - 1) ? 4'd0 : p_slot + 4'd1;
      end else if (k == KEY_STORE) begin
        if (!p_preset) begin
          p_work[addr] = fq;
          r.sv = 1'b1;
        end else if (p_mode == MODE_OFF) r.sv = 1'b1;
        if (r.sv) begin
          p_saved[addr] = p_work[addr];
          r.ss = 7'(addr);
          r.sd = p_work[addr];
          p_flash = FLASH_LEN;
        end
      end
    end
    p_last = k;
    r.pa = p_preset;
    r.drv = p_drive;
  endtask

  // Hand one item to the block and record what it should yield.
  // Valid drops only when a gap follows, so it changes once per time step.
  task automatic send_item(input logic [4:0] k, input logic [21:0] dial,
                           input bit has_exp, input panel_out_t typed);
    panel_out_t r;
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_key <= k;
    in_dial_freq <= dial;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    step_panel(k, dial, r);
    pending_panels.push_back(r);
    typed_panels.push_back(typed);
    typed_flags.push_back(has_exp);
  endtask

  // Random BCD-ish dial value; mostly valid digits, sometimes any bits.
  function automatic logic [21:0] rand_dial();
    logic [21:0] v;
    if ($urandom_range(0, 3) == 0) return 22'($urandom);
    v = '0;
    for (int i = 0; i < 5; i++) v[4 * i +: 4] = 4'($urandom_range(0, 9));
    v[21:20] = 2'($urandom_range(0, 3));
    return v;
  endfunction

  // Keys arrive mostly as press then release, the release sometimes a raw noise code; else the press stands alone.
  task automatic press(input logic [4:0] k);
    send_item(k, rand_dial(), 1'b0, '0);
    if ($urandom_range(0, 9) != 0)
      send_item($urandom_range(0, 3) == 0 ? 5'($urandom_range(18, 31)) : KEY_NONE,
                rand_dial(), 1'b0, '0);
  endtask

  // Stimulus.
  initial begin
    step_row_t rows[$];
    step_row_t row;
    panel_out_t e;
    logic [4:0] k;
    int sel;
    reset_panel();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First tick after reset: dial shown, blanks, bank A slot 0, lines released.
    e = '0;
    e.segs = {8'h00, 8'h00, 8'h7E, 8'h7E, 8'hFE, 8'h7E, 8'h77, 8'h7E};
    e.drv = '1;
    rows.push_back('{KEY_DIGIT0, 22'h0, 1'b1, e});
    e.segs = {8'hB0, 8'hFF, 8'h7B, 8'h47, 8'hC7, 8'h47, 8'h77, 8'h7E};
    rows.push_back('{KEY_NONE, 22'h3FFFFF, 1'b0, e});
    rows.push_back('{KEY_STORE, 22'h3FFFFF, 1'b0, e});
    rows.push_back('{5'd31, 22'h123456, 1'b0, e});
    rows.push_back('{KEY_PRESET, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_DIGIT9, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_BANK_DN, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_DIGIT0 + 5'd7, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_ENTER, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_BANK_DN, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_SLOT_DN, 22'h0, 1'b0, e});
    rows.push_back('{5'd18, 22'h0, 1'b0, e});
    rows.push_back('{KEY_STORE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_BANK_UP, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_SLOT_UP, 22'h0, 1'b0, e});
    rows.push_back('{KEY_NONE, 22'h0, 1'b0, e});
    rows.push_back('{KEY_ENTER, 22'h0, 1'b0, e});
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.key, row.dial, row.has_exp, row.exp);
    end

    // Long receiver hold-off while the sender keeps offering items.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) press(5'($urandom_range(0, 17)));
    // Pause until every result is back.
    in_valid <= 1'b0;
    wait (pending_panels.size() == 0);

    // Random part: press/release sequences with bias toward preset work.
    for (int n = 0; n < RAND_ITEMS / 2; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) k = 5'($urandom_range(0, 9));
      else if (sel < 45) k = KEY_ENTER;
      else if (sel < 52) k = KEY_PRESET;
      else if (sel < 84) k = 5'($urandom_range(12, 15));
      else if (sel < 94) k = KEY_STORE;
      else k = 5'($urandom_range(17, 31));
      press(k);
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
      if (gap == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    panel_out_t got, want, typed;
    bit has_typed;
    if (rst_n && out_valid && out_ready) begin
      got = {out_display_segments, out_intensity_write, out_intensity_level,
             out_preset_active, out_drive_freq, out_save_valid, out_save_slot,
             out_save_data};
      if (pending_panels.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        errors++;
      end else begin
        want = pending_panels.pop_front();
        typed = typed_panels.pop_front();
        has_typed = typed_flags.pop_front();
        if (has_typed && typed != want) begin
          $display("%0t: predictor disagrees with table: expected %h actual %h",
                   $time, typed, want);
          errors++;
        end
        if (got.segs != want.segs) begin
          $display("%0t: segments expected %h actual %h", $time, want.segs, got.segs);
          errors++;
        end
        if (got.iw != want.iw || got.il != want.il) begin
          $display("%0t: intensity expected %b/%h actual %b/%h", $time,
                   want.iw, want.il, got.iw, got.il);
          errors++;
        end
        if (got.pa != want.pa || got.drv != want.drv) begin
          $display("%0t: drive expected %b/%h actual %b/%h", $time,
                   want.pa, want.drv, got.pa, got.drv);
          errors++;
        end
        if (got.sv != want.sv || got.ss != want.ss || got.sd != want.sd) begin
          $display("%0t: save expected %b/%0d/%h actual %b/%0d/%h", $time,
                   want.sv, want.ss, want.sd, got.sv, got.ss, got.sd);
          errors++;
        end
      end
    end
  end

  // Wrap-up once the stimulus is done and everything has drained.
  initial begin
    wait (sender_done);
    wait (pending_panels.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
